@@ sv/mrc_pkg.sv @@
// Shared types, constants and the long-division step for the mixed-radix converter.
package mrc_pkg;

	localparam int RADIX_BITS       = 16;
	localparam int FLAT_BITS        = 64;
	localparam int NUM_DIGITS       = 4;
	localparam int BITS_PER_STAGE   = 8;
	localparam int STAGES_PER_DIGIT = FLAT_BITS / BITS_PER_STAGE;
	localparam int DEF_MAX_DIGITS   = 4;
	localparam int CFG_IDX_BITS     = 3;
	localparam int COUNT_BITS       = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_DIGITS_USED = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIX_0     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIX_1     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIX_2     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIX_3     = 3'd4;

	// Operation codes
	localparam logic OP_TO_INDEX  = 1'b0;
	localparam logic OP_TO_DIGITS = 1'b1;

	typedef logic [RADIX_BITS-1:0] radix_t;
	typedef logic [FLAT_BITS-1:0]  flat_t;

	// Classified request as held in the queue
	typedef struct packed {
		logic                     op;
		radix_t [NUM_DIGITS-1:0]  radix;
		flat_t                    flat;
		radix_t [NUM_DIGITS-1:0]  digit;
	} req_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic valid;
		req_t req;
	} head_t;

	// Contents of one back-end pipeline stage
	typedef struct packed {
		logic                     op;
		radix_t [NUM_DIGITS-1:0]  radix;
		flat_t                    w;
		radix_t                   rem;
		radix_t [NUM_DIGITS-1:0]  dig;
		flat_t                    acc;
		flat_t                    space;
	} stage_t;

	// Several restoring division steps: remainder in the top part, work word below
	function automatic logic [RADIX_BITS+FLAT_BITS-1:0] div_steps(
		input radix_t rem, input flat_t w, input radix_t r);
		logic [RADIX_BITS:0] t;
		radix_t              rm;
		flat_t               ww;
		logic                q;
		rm = rem;
		ww = w;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			t = {rm, ww[FLAT_BITS-1]};
			q = (t >= {1'b0, r});
			if (q) begin
				t = t - {1'b0, r};
			end
			rm = t[RADIX_BITS-1:0];
			ww = {ww[FLAT_BITS-2:0], q};
		end
		return {rm, ww};
	endfunction

endpackage

@@ sv/mrc_front.sv @@
// Front end: classifies requests against the configuration and queues them.
module mrc_front import mrc_pkg::*; #(
	parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       operation,
	input  flat_t                      flat_in,
	input  radix_t [NUM_DIGITS-1:0]    digit_in,
	input  logic [COUNT_BITS-1:0]      digits_used,
	input  radix_t [NUM_DIGITS-1:0]    radix_cfg,
	input  logic                       pop,
	output head_t                      head
);

	localparam int QDEPTH = 2;

	logic [COUNT_BITS-1:0] n_eff;
	req_t                  req;
	req_t                  mem_q [QDEPTH];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            cnt_q;
	logic                  push;

	// Clamp the digit count, fold unused and zero radices to one
	always_comb begin
		if (digits_used < 3'd2) begin
			n_eff = 3'd2;
		end else if (digits_used > COUNT_BITS'(MAX_DIGITS)) begin
			n_eff = COUNT_BITS'(MAX_DIGITS);
		end else begin
			n_eff = digits_used;
		end
		req.op   = operation;
		req.flat = flat_in;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (COUNT_BITS'(i) < n_eff) begin
				req.radix[i] = (radix_cfg[i] == '0) ? RADIX_BITS'(1) : radix_cfg[i];
				req.digit[i] = digit_in[i];
			end else begin
				req.radix[i] = RADIX_BITS'(1);
				req.digit[i] = '0;
			end
		end
	end

	assign in_ready = (cnt_q != 2'(QDEPTH));
	assign push     = in_valid && in_ready;

	// Two-entry request queue
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.req   = mem_q[rd_ptr_q];

endmodule

@@ sv/mrc_back.sv @@
// Back end: pipelined divider chain, Horner accumulation and space size.
module mrc_back import mrc_pkg::*; #(
	parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  head_t                   head,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output flat_t                   flat_out,
	output radix_t [NUM_DIGITS-1:0] digit_out,
	output flat_t                   space_size
);

	localparam int NS = MAX_DIGITS * STAGES_PER_DIGIT;

	logic   adv;
	logic   vld_s [NS];
	stage_t stg_s [NS];
	logic   out_valid_s;
	stage_t out_s;
	stage_t last_stg;

	// Whole pipeline moves unless the result register is held
	assign adv = !out_valid_s || out_ready;
	assign pop = adv && head.valid;

	for (genvar s = 0; s < NS; s++) begin : g_stage
		localparam int P = s / STAGES_PER_DIGIT;
		localparam int K = s % STAGES_PER_DIGIT;
		stage_t                      src;
		stage_t                      nxt;
		logic                        src_v;
		radix_t                      rem_in;
		logic [2*RADIX_BITS-1:0]     m_lo;
		logic [3*RADIX_BITS-1:0]     m_mid;
		flat_t                       m_hi;

		if (s == 0) begin : g_src0
			always_comb begin
				src_v     = head.valid;
				src.op    = head.req.op;
				src.radix = head.req.radix;
				src.w     = head.req.flat;
				src.rem   = '0;
				src.dig   = head.req.digit;
				src.acc   = '0;
				src.space = '0;
			end
		end else begin : g_srcn
			always_comb begin
				src_v = vld_s[s-1];
				src   = stg_s[s-1];
			end
		end

		// Division step plus the multiply work of the first three stages
		always_comb begin
			rem_in = (K == 0) ? '0 : src.rem;
			nxt    = src;
			{nxt.rem, nxt.w} = div_steps(rem_in, src.w, src.radix[P]);
			if (K == 0 && P > 0) begin
				nxt.dig[(P > 0) ? P-1 : 0] = src.rem;
			end
			m_lo  = '0;
			m_mid = '0;
			m_hi  = '0;
			if (s == 0) begin
				m_lo      = src.radix[2] * src.dig[3];
				nxt.acc   = FLAT_BITS'(m_lo) + FLAT_BITS'(src.dig[2]);
				m_lo      = src.radix[0] * src.radix[1];
				nxt.space = FLAT_BITS'(m_lo);
			end else if (s == 1) begin
				m_mid     = src.radix[1] * src.acc[2*RADIX_BITS-1:0];
				nxt.acc   = FLAT_BITS'(m_mid) + FLAT_BITS'(src.dig[1]);
				m_mid     = src.radix[2] * src.space[2*RADIX_BITS-1:0];
				nxt.space = FLAT_BITS'(m_mid);
			end else if (s == 2) begin
				m_hi      = src.radix[0] * src.acc[3*RADIX_BITS-1:0];
				nxt.acc   = m_hi + FLAT_BITS'(src.dig[0]);
				m_hi      = src.radix[3] * src.space[3*RADIX_BITS-1:0];
				nxt.space = m_hi;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (adv) begin
				vld_s[s] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stg_s[s] <= nxt;
			end
		end
	end

	// Last remainder lands in the top digit in use
	always_comb begin
		last_stg                   = stg_s[NS-1];
		last_stg.dig[MAX_DIGITS-1] = stg_s[NS-1].rem;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s <= 1'b0;
		end else if (adv) begin
			out_valid_s <= vld_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s <= last_stg;
		end
	end

	assign out_valid  = out_valid_s;
	assign space_size = out_s.space;
	assign flat_out   = (out_s.op == OP_TO_DIGITS) ? '0 : out_s.acc;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (out_s.op == OP_TO_DIGITS && i < MAX_DIGITS) begin
				digit_out[i] = out_s.dig[i];
			end else begin
				digit_out[i] = '0;
			end
		end
	end

endmodule

@@ sv/mixed_radix_index_converter.sv @@
// Top level of the mixed-radix index converter: configuration registers and wiring.
//
//  channel | signals                          | role
//  --------+----------------------------------+-------------------------------
//  cfg     | cfg_valid cfg_ready cfg_index    | register writes, always ready
//          | cfg_data                         |
//  in      | in_valid in_ready operation ...  | conversion requests
//  out     | out_valid out_ready flat_out ... | one result per request
//
// One request per cycle sustained while out_ready holds. A request passes the queue,
// the divider chain, which retires eight quotient bits per stage over MAX_DIGITS
// passes of 64 bits, and the result register.
// Reset restores digits_used 4 and every radix 2, and empties queue and pipeline.
// A held result stalls the whole back pipeline; the two-entry queue then fills
// before in_ready drops.
module mixed_radix_index_converter import mrc_pkg::*; #(
	parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  radix_t                  cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    operation,
	input  flat_t                   flat_in,
	input  radix_t                  digit_in_0,
	input  radix_t                  digit_in_1,
	input  radix_t                  digit_in_2,
	input  radix_t                  digit_in_3,
	output logic                    out_valid,
	input  logic                    out_ready,
	output flat_t                   flat_out,
	output radix_t                  digit_out_0,
	output radix_t                  digit_out_1,
	output radix_t                  digit_out_2,
	output radix_t                  digit_out_3,
	output flat_t                   space_size
);

	logic [COUNT_BITS-1:0]   digits_used_q;
	radix_t [NUM_DIGITS-1:0] radix_q;
	head_t                   head;
	logic                    pop;
	radix_t [NUM_DIGITS-1:0] digit_out;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_used_q <= COUNT_BITS'(4);
			for (int i = 0; i < NUM_DIGITS; i++) begin
				radix_q[i] <= RADIX_BITS'(2);
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DIGITS_USED: digits_used_q <= cfg_data[COUNT_BITS-1:0];
				REG_RADIX_0:     radix_q[0]    <= cfg_data;
				REG_RADIX_1:     radix_q[1]    <= cfg_data;
				REG_RADIX_2:     radix_q[2]    <= cfg_data;
				REG_RADIX_3:     radix_q[3]    <= cfg_data;
				default: ;
			endcase
		end
	end

	mrc_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.flat_in     (flat_in),
		.digit_in    ({digit_in_3, digit_in_2, digit_in_1, digit_in_0}),
		.digits_used (digits_used_q),
		.radix_cfg   (radix_q),
		.pop         (pop),
		.head        (head)
	);

	mrc_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.flat_out   (flat_out),
		.digit_out  (digit_out),
		.space_size (space_size)
	);

	assign digit_out_0 = digit_out[0];
	assign digit_out_1 = digit_out[1];
	assign digit_out_2 = digit_out[2];
	assign digit_out_3 = digit_out[3];

`ifndef SYNTHESIS
	// The space size is a product of non-zero radices
	a_space_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> space_size != '0)
		else $error("zero space size");

	// A result carries either a flat index or digits, never both
	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flat_out != '0 |->
			digit_out_0 == '0 && digit_out_1 == '0 && digit_out_2 == '0 && digit_out_3 == '0)
		else $error("flat index and digits both set");

	// A request cannot be popped from an empty queue
	a_pop_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");
`endif

endmodule

@@ bench/mixed_radix_index_converter_test.sv @@
// Self-checking testbench for the mixed-radix index converter.
`timescale 1ns / 100ps

module mixed_radix_index_converter_test;
	import mrc_pkg::*;

	localparam int LATENCY = 4 * 8 + 2;

	typedef struct {
		logic   op;
		flat_t  flat;
		radix_t dig [4];
	} conv_req_t;

	typedef struct {
		flat_t  flat;
		radix_t dig [4];
		flat_t  space;
	} conv_res_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	radix_t cfg_data;
	logic in_valid;
	logic in_ready;
	logic operation;
	flat_t flat_in;
	radix_t digit_in_0, digit_in_1, digit_in_2, digit_in_3;
	logic out_valid;
	logic out_ready;
	flat_t flat_out;
	radix_t digit_out_0, digit_out_1, digit_out_2, digit_out_3;
	flat_t space_size;

	mixed_radix_index_converter dut (.*);

	// shadow copy of the configuration registers
	logic [2:0] count_reg;
	radix_t radix_reg [4];

	conv_req_t pending_reqs [$];
	conv_res_t expected_results [$];
	int errors;
	int in_gap, out_gap;
	bit in_taken;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// overall time limit
	initial begin
		#50ms;
		$display("mixed_radix_index_converter_test failed");
		$finish;
	end

	// expected result of one request under the current configuration
	function automatic conv_res_t convert(conv_req_t rq);
		conv_res_t res;
		int n;
		flat_t r, v, mult;
		n = count_reg < 2 ? 2 : (count_reg > 4 ? 4 : count_reg);
		res.flat = '0;
		res.space = 64'd1;
		for (int i = 0; i < 4; i++) res.dig[i] = '0;
		v = rq.flat;
		mult = 64'd1;
		for (int i = 0; i < n; i++) begin
			r = (radix_reg[i] == 0) ? 64'd1 : {48'd0, radix_reg[i]};
			res.space = res.space * r;
			if (rq.op == OP_TO_DIGITS) begin
				res.dig[i] = radix_t'(v % r);
				v = v / r;
			end else begin
				res.flat = res.flat + mult * {48'd0, rq.dig[i]};
				mult = mult * r;
			end
		end
		return res;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input radix_t val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_DIGITS_USED) count_reg = val[2:0];
		else radix_reg[2'(idx - REG_RADIX_0)] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every request has been answered, then let the pipeline settle
	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic radix_t rand_digit();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return radix_t'($urandom);
		endcase
	endfunction

	function automatic conv_req_t rand_req();
		conv_req_t rq;
		rq.op = $urandom_range(0, 1) ? OP_TO_DIGITS : OP_TO_INDEX;
		case ($urandom_range(0, 3))
			0: rq.flat = '1;
			1: rq.flat = {32'd0, 32'($urandom)} % 64'd100000;
			default: rq.flat = {32'($urandom), 32'($urandom)};
		endcase
		for (int i = 0; i < 4; i++) rq.dig[i] = rand_digit();
		return rq;
	endfunction

	task automatic push(input conv_req_t rq);
		pending_reqs.push_back(rq);
	endtask

	// request driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else if (in_valid && !in_taken) begin
			// hold the request
		end else if (in_gap > 0) begin
			in_valid <= 1'b0;
			in_gap <= in_gap - 1;
		end else if (pending_reqs.size() != 0) begin
			conv_req_t rq;
			rq = pending_reqs.pop_front();
			in_valid <= 1'b1;
			operation <= rq.op;
			flat_in <= rq.flat;
			digit_in_0 <= rq.dig[0];
			digit_in_1 <= rq.dig[1];
			digit_in_2 <= rq.dig[2];
			digit_in_3 <= rq.dig[3];
			in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// predict on acceptance
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			conv_req_t rq;
			rq.op = operation;
			rq.flat = flat_in;
			rq.dig[0] = digit_in_0;
			rq.dig[1] = digit_in_1;
			rq.dig[2] = digit_in_2;
			rq.dig[3] = digit_in_3;
			expected_results.push_back(convert(rq));
		end
	end

	// result back-pressure
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap <= 0;
		end else if (out_gap > 0) begin
			out_ready <= 1'b0;
			out_gap <= out_gap - 1;
		end else begin
			out_ready <= 1'b1;
			if (out_valid && out_ready)
				out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				conv_res_t ex;
				ex = expected_results.pop_front();
				if (flat_out !== ex.flat) begin
					$error("flat_out expected %0d got %0d", ex.flat, flat_out);
					errors++;
				end
				if (digit_out_0 !== ex.dig[0]) begin
					$error("digit_out_0 expected %0d got %0d", ex.dig[0], digit_out_0);
					errors++;
				end
				if (digit_out_1 !== ex.dig[1]) begin
					$error("digit_out_1 expected %0d got %0d", ex.dig[1], digit_out_1);
					errors++;
				end
				if (digit_out_2 !== ex.dig[2]) begin
					$error("digit_out_2 expected %0d got %0d", ex.dig[2], digit_out_2);
					errors++;
				end
				if (digit_out_3 !== ex.dig[3]) begin
					$error("digit_out_3 expected %0d got %0d", ex.dig[3], digit_out_3);
					errors++;
				end
				if (space_size !== ex.space) begin
					$error("space_size expected %0d got %0d", ex.space, space_size);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		conv_req_t rq;
		int n_cfg;
		errors = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DIGITS_USED;
		cfg_data = '0;
		operation = OP_TO_INDEX;
		flat_in = '0;
		digit_in_0 = '0;
		digit_in_1 = '0;
		digit_in_2 = '0;
		digit_in_3 = '0;
		count_reg = 3'd4;
		for (int i = 0; i < 4; i++) radix_reg[i] = 16'd2;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset configuration, field extremes, both directions
		rq.flat = '0;
		for (int i = 0; i < 4; i++) rq.dig[i] = '0;
		rq.op = OP_TO_DIGITS; push(rq);
		rq.flat = 64'd15; push(rq);
		rq.flat = '1; push(rq);
		rq.op = OP_TO_INDEX; push(rq);
		for (int i = 0; i < 4; i++) rq.dig[i] = 16'd1;
		push(rq);
		for (int i = 0; i < 4; i++) rq.dig[i] = '1;
		push(rq);
		drain();

		// directed: largest radices, zero radix, out-of-range digit count
		for (int i = 0; i < 4; i++) write_reg(CFG_IDX_BITS'(REG_RADIX_0 + i), 16'hFFFF);
		write_reg(REG_DIGITS_USED, 16'd7);
		rq.op = OP_TO_DIGITS; rq.flat = '1; push(rq);
		rq.op = OP_TO_INDEX; push(rq);
		drain();
		write_reg(REG_RADIX_1, 16'd0);
		write_reg(REG_DIGITS_USED, 16'd0);
		rq.op = OP_TO_DIGITS; rq.flat = 64'h0123_4567_89AB_CDEF; push(rq);
		rq.op = OP_TO_INDEX; push(rq);
		drain();
		write_reg(REG_DIGITS_USED, 16'd3);
		write_reg(REG_RADIX_0, 16'd1);
		rq.op = OP_TO_DIGITS; push(rq);
		rq.op = OP_TO_INDEX; push(rq);
		drain();

		// random phases, each under a fresh configuration
		for (int ph = 0; ph < 14; ph++) begin
			n_cfg = $urandom_range(0, 2);
			write_reg(REG_DIGITS_USED, radix_t'($urandom_range(0, 7)));
			for (int i = 0; i < 4; i++) begin
				case (n_cfg)
					0: write_reg(CFG_IDX_BITS'(REG_RADIX_0 + i),
						radix_t'($urandom_range(0, 12)));
					1: write_reg(CFG_IDX_BITS'(REG_RADIX_0 + i), radix_t'($urandom));
					default: write_reg(CFG_IDX_BITS'(REG_RADIX_0 + i),
						$urandom_range(0, 1) ? 16'hFFFF : radix_t'($urandom_range(0, 300)));
				endcase
			end
			for (int k = 0; k < 100; k++) push(rand_req());
			drain();
		end

		if (errors == 0)
			$display("mixed_radix_index_converter_test passed");
		else
			$display("mixed_radix_index_converter_test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/mrc_pkg.sv
sv/mrc_front.sv
sv/mrc_back.sv
sv/mixed_radix_index_converter.sv
bench/mixed_radix_index_converter_test.sv
